FILE: hdl/kdsp_pkg.sv
// kdsp_pkg: shared types, constants and helpers for the keying despill block.
// No dependencies; imported by kdsp_cfg_regs and keying_despill_pixel.
package kdsp_pkg;

  // Q12 factor format
  localparam int Q_SHIFT = 12;
  localparam int Q_BITS  = 13;
  localparam logic [Q_BITS-1:0] Q_ONE      = 13'd4096;
  localparam logic [Q_BITS-1:0] Q_HALF     = 13'd2048;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DESPILL_STRENGTH = 2'd0,
    REG_BALANCE_WEIGHT   = 2'd1
  } cfg_reg_t;

  // color channel index
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // register file contents seen by the datapath
  typedef struct packed {
    logic [Q_BITS-1:0] strength;
    logic [Q_BITS-1:0] balance;
  } kdsp_cfg_t;

  // keep the low 13 bits and clamp to 1.0
  function automatic logic [Q_BITS-1:0] sat_q12(input logic [CFG_DATA_BITS-1:0] value);
    logic [Q_BITS-1:0] w;
    w = value[Q_BITS-1:0];
    return (w > Q_ONE) ? Q_ONE : w;
  endfunction

endpackage

FILE: hdl/kdsp_cfg_regs.sv
// kdsp_cfg_regs: despill strength and balance weight registers.
// Depends on kdsp_pkg (cfg_reg_t, kdsp_cfg_t, sat_q12).
module kdsp_cfg_regs import kdsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output kdsp_cfg_t                 cfg
);

  // write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength <= Q_HALF;
      cfg.balance  <= Q_HALF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DESPILL_STRENGTH: cfg.strength <= sat_q12(cfg_data);
        REG_BALANCE_WEIGHT:   cfg.balance  <= sat_q12(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/keying_despill_pixel.sv
// keying_despill_pixel: per-pixel chroma key spill suppression, top level.
// Depends on kdsp_pkg and kdsp_cfg_regs.
//
// One pixel is taken every clock: busy stays low, so a start is always a
// transfer. Each pixel's result appears with a one-cycle done strobe, in
// order, after passing the five register stages: key select, weight
// multiply, excess subtract, strength multiply and clamp. The receiver cannot
// hold results off. Configuration writes are always ready and are meant to
// land while no pixel is in flight.
module keying_despill_pixel import kdsp_pkg::*; #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [CHANNEL_BITS-1:0]   fg_red,
  input  logic [CHANNEL_BITS-1:0]   fg_green,
  input  logic [CHANNEL_BITS-1:0]   fg_blue,
  input  logic [CHANNEL_BITS-1:0]   fg_alpha,
  input  logic [CHANNEL_BITS-1:0]   key_red,
  input  logic [CHANNEL_BITS-1:0]   key_green,
  input  logic [CHANNEL_BITS-1:0]   key_blue,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      done,
  output logic [CHANNEL_BITS-1:0]   out_red,
  output logic [CHANNEL_BITS-1:0]   out_green,
  output logic [CHANNEL_BITS-1:0]   out_blue,
  output logic [CHANNEL_BITS-1:0]   out_alpha
);

  localparam int CB     = CHANNEL_BITS;
  localparam int PW     = CB + Q_BITS;        // weighted channel width
  localparam int EW     = CB + Q_SHIFT;       // excess width
  localparam int MW     = EW + Q_BITS;        // strength product width
  localparam int LAT    = 5;

  kdsp_cfg_t cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  kdsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: dominant key channel and operand select
  chan_t          dom_sel;
  logic [CB-1:0]  c_dom, c_lo, c_hi;

  always_comb begin
    if (key_red > key_green) begin
      dom_sel = (key_red > key_blue) ? CH_RED : CH_BLUE;
    end else begin
      dom_sel = (key_green > key_blue) ? CH_GREEN : CH_BLUE;
    end
  end

  always_comb begin
    unique case (dom_sel)
      CH_RED: begin
        c_dom = fg_red;   c_lo = fg_green; c_hi = fg_blue;
      end
      CH_GREEN: begin
        c_dom = fg_green; c_lo = fg_red;   c_hi = fg_blue;
      end
      default: begin
        c_dom = fg_blue;  c_lo = fg_red;   c_hi = fg_green;
      end
    endcase
  end

  logic           s1_valid;
  chan_t          s1_dom;
  logic [CB-1:0]  s1_c_dom, s1_c_lo, s1_c_hi;
  logic [CB-1:0]  s1_fg [3];
  logic [CB-1:0]  s1_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_dom   <= dom_sel;
    s1_c_dom <= c_dom;
    s1_c_lo  <= c_lo;
    s1_c_hi  <= c_hi;
    s1_fg[0] <= fg_red;
    s1_fg[1] <= fg_green;
    s1_fg[2] <= fg_blue;
    s1_alpha <= fg_alpha;
  end

  // ---------------- stage 2: balance-weighted products
  logic [Q_BITS-1:0] bal_hi;
  assign bal_hi = Q_ONE - cfg.balance;

  logic           s2_valid;
  chan_t          s2_dom;
  logic [CB-1:0]  s2_c_dom;
  logic [PW-1:0]  s2_p_lo, s2_p_hi;
  logic [CB-1:0]  s2_fg [3];
  logic [CB-1:0]  s2_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_dom   <= s1_dom;
    s2_c_dom <= s1_c_dom;
    s2_p_lo  <= {{Q_BITS{1'b0}}, s1_c_lo} * {{CB{1'b0}}, cfg.balance};
    s2_p_hi  <= {{Q_BITS{1'b0}}, s1_c_hi} * {{CB{1'b0}}, bal_hi};
    s2_fg    <= s1_fg;
    s2_alpha <= s1_alpha;
  end

  // ---------------- stage 3: excess of dominant channel over the average
  logic [PW-1:0] avg, dom_q, diff;
  assign avg   = s2_p_lo + s2_p_hi;
  assign dom_q = {1'b0, s2_c_dom, {Q_SHIFT{1'b0}}};
  assign diff  = dom_q - avg;

  logic           s3_valid;
  chan_t          s3_dom;
  logic [CB-1:0]  s3_c_dom;
  logic           s3_pos;
  logic [EW-1:0]  s3_excess;
  logic [CB-1:0]  s3_fg [3];
  logic [CB-1:0]  s3_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_dom    <= s2_dom;
    s3_c_dom  <= s2_c_dom;
    s3_pos    <= dom_q > avg;
    s3_excess <= diff[EW-1:0];
    s3_fg     <= s2_fg;
    s3_alpha  <= s2_alpha;
  end

  // ---------------- stage 4: strength times excess, truncated
  logic [MW-1:0] spill_prod;
  assign spill_prod = {{Q_BITS{1'b0}}, s3_excess} * {{EW{1'b0}}, cfg.strength};

  logic           s4_valid;
  chan_t          s4_dom;
  logic [CB-1:0]  s4_c_dom;
  logic [CB:0]    s4_amount;
  logic [CB-1:0]  s4_fg [3];
  logic [CB-1:0]  s4_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_dom    <= s3_dom;
    s4_c_dom  <= s3_c_dom;
    s4_amount <= s3_pos ? spill_prod[MW-1:2*Q_SHIFT] : '0;
    s4_fg     <= s3_fg;
    s4_alpha  <= s3_alpha;
  end

  // ---------------- stage 5: subtract with clamp at zero, output register
  logic [CB-1:0] new_dom;
  assign new_dom = (s4_amount >= {1'b0, s4_c_dom}) ? '0 : s4_c_dom - s4_amount[CB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= (s4_dom == CH_RED)   ? new_dom : s4_fg[0];
    out_green <= (s4_dom == CH_GREEN) ? new_dom : s4_fg[1];
    out_blue  <= (s4_dom == CH_BLUE)  ? new_dom : s4_fg[2];
    out_alpha <= s4_alpha;
  end

  // ---------------- checks
  // every result comes from a matching earlier transfer
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done without a matching start");

  // alpha is carried unchanged through the pipe
  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> out_alpha == $past(fg_alpha, LAT))
    else $error("alpha mismatch");

  // despill only ever lowers a channel
  a_no_gain: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_red <= $past(fg_red, LAT)) && (out_green <= $past(fg_green, LAT))
             && (out_blue <= $past(fg_blue, LAT)))
    else $error("channel increased");

  // factors stay within 1.0
  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    (cfg.strength <= Q_ONE) && (cfg.balance <= Q_ONE))
    else $error("factor above one");

endmodule
